@@ rtl/core/wfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_pkg - shared types and constants for the wave grid step unit
// Grid geometry, fixed-point formats, CORDIC angle table, FSM and handshake
// structs used between the controller and the datapath.
// ----------------------------------------------------------------------------
package wfs_pkg;

  // Grid geometry and cell format
  localparam int GRID_COLS = 120;
  localparam int GRID_ROWS = 40;
  localparam int CELL_BITS = 32;
  localparam int NCELLS    = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W    = $clog2(NCELLS);
  localparam int CIDX_W    = $clog2(GRID_COLS);
  localparam int RIDX_W    = $clog2(GRID_ROWS);
  localparam int NUM_RAMS  = 3;
  localparam int SEL_W     = $clog2(NUM_RAMS);

  // Port field widths
  localparam int KIND_W  = 2;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Source position in tenths of a column
  localparam int TENTHS_W  = 12;
  localparam int QUOT_W    = TENTHS_W - 3;
  localparam int POS_RESET = 600;
  localparam int POS_STEP  = 6;
  localparam int A_LIMIT   = (GRID_COLS - 5) * 10;
  localparam int B_LIMIT   = 50;

  // Stencil sweep: reads run one column ahead, then the pipeline drains
  localparam int SWEEP_LEN = NCELLS + GRID_ROWS + 6;
  localparam int SWEEP_W   = $clog2(SWEEP_LEN);

  // Datapath widths
  localparam int WIDE_W = 2 * CELL_BITS + 8;
  localparam int LAP_W  = CELL_BITS + 3;
  localparam int NV_W   = CELL_BITS + 5;
  localparam int PG_W   = LAP_W + 17;
  localparam int PD_W   = NV_W + 17;
  localparam int Q16_ROUND = 32768;

  // Source amplitudes and sine generator
  localparam logic [31:0] PHASE_STEP = 32'd273426110;
  localparam int SRC_AMP_Q = 30;
  localparam int SPIN_AMP  = 786432;
  localparam int POKE_AMP  = 983040;
  localparam int CORDIC_X0 = 19898;
  localparam int CORDIC_W  = 20;
  localparam int CORDIC_N  = 16;
  localparam int CSTEP_W   = $clog2(CORDIC_N);

  localparam logic signed [WIDE_W-1:0] CELL_MAX =
    WIDE_W'((128'sd1 <<< (CELL_BITS - 1)) - 128'sd1);
  localparam logic signed [WIDE_W-1:0] CELL_MIN = -CELL_MAX - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] VAL_MAX  = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] VAL_MIN  = -VAL_MAX - WIDE_W'(1);

  // Register map (index = paddr[2])
  localparam logic REG_WAVE_GAIN = 1'b0;
  localparam logic REG_DAMPING   = 1'b1;
  localparam logic [CFG_W-1:0] GAIN_RESET = 16'd13107;
  localparam logic [CFG_W-1:0] DAMP_RESET = 16'd62915;

  // Initial grid roles
  localparam logic [SEL_W-1:0] SEL_CUR0 = SEL_W'(0);
  localparam logic [SEL_W-1:0] SEL_PRV0 = SEL_W'(1);
  localparam logic [SEL_W-1:0] SEL_WRK0 = SEL_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_POKE    = 2'd1,
    KIND_MEASURE = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_SRC_A,
    ST_SRC_B,
    ST_POKE_RD,
    ST_POKE_WR,
    ST_READ_RD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic sweep_step;
    logic src_a_wr;
    logic src_b_wr;
    logic rotate;
    logic poke_rd;
    logic poke_wr;
    logic read_rd;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  sweep_last;
    kind_t kind;
    logic  poke_ok;
    logic  read_ok;
    logic  out_free;
  } dp_stat_t;

  // CORDIC angle table, turn fraction with 2^32 = 2*pi
  function automatic logic signed [31:0] atan_turn(input logic [CSTEP_W-1:0] idx);
    logic signed [31:0] r;
    case (idx)
      4'd0:    r = 32'sd536870912;
      4'd1:    r = 32'sd316933406;
      4'd2:    r = 32'sd167458907;
      4'd3:    r = 32'sd85004756;
      4'd4:    r = 32'sd42667331;
      4'd5:    r = 32'sd21354465;
      4'd6:    r = 32'sd10679838;
      4'd7:    r = 32'sd5340245;
      4'd8:    r = 32'sd2670163;
      4'd9:    r = 32'sd1335087;
      4'd10:   r = 32'sd667544;
      4'd11:   r = 32'sd333772;
      4'd12:   r = 32'sd166886;
      4'd13:   r = 32'sd83443;
      4'd14:   r = 32'sd41722;
      4'd15:   r = 32'sd20861;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // x / 10 by reciprocal multiply, exact over the whole input range
  function automatic logic [QUOT_W-1:0] div10(input logic [TENTHS_W-1:0] x);
    logic [TENTHS_W+12:0] p;
    p = (TENTHS_W + 13)'(x) * (TENTHS_W + 13)'(6554);
    return p[TENTHS_W+12:16];
  endfunction

  function automatic logic signed [CELL_BITS-1:0] sat_cell(
    input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v > CELL_MAX) r = CELL_MAX;
    else if (v < CELL_MIN) r = CELL_MIN;
    else r = v;
    return r[CELL_BITS-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_value(
    input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v > VAL_MAX) r = VAL_MAX;
    else if (v < VAL_MIN) r = VAL_MIN;
    else r = v;
    return r[VALUE_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/wfs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_if - request and result channels of the wave grid step unit
// Valid/ready channels; a request or result moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface wfs_item_if import wfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [COL_W-1:0]  cell_col;
  logic [ROW_W-1:0]  cell_row;
  logic              spin_up;

  modport source (output valid, kind, cell_col, cell_row, spin_up, input ready);
  modport sink   (input valid, kind, cell_col, cell_row, spin_up, output ready);
endinterface

interface wfs_result_if import wfs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] cell_value;
  logic                      is_measured;
  logic                      spin_positive;
  logic [COL_W-1:0]          col_a;
  logic [COL_W-1:0]          col_b;

  modport source (output valid, cell_value, is_measured, spin_positive, col_a, col_b,
                  input ready);
  modport sink   (input valid, cell_value, is_measured, spin_positive, col_a, col_b,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/wfs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_ram - simple dual-port grid memory
// One write port and one read port with registered read data; read data holds
// while re is low.
// ----------------------------------------------------------------------------
module wfs_ram #(
  parameter int DEPTH = 4800,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wfs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_ctrl - sequencing state machine
// Runs the post-reset clear, decodes each request and steps the datapath
// through sweep, source writes, poke, read and result hand-off.
// ----------------------------------------------------------------------------
module wfs_ctrl import wfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_TICK:    state_next = ST_SWEEP;
          KIND_POKE:    state_next = stat.poke_ok ? ST_POKE_RD : ST_FINISH;
          KIND_MEASURE: state_next = ST_FINISH;
          KIND_READ:    state_next = stat.read_ok ? ST_READ_RD : ST_FINISH;
          default:      state_next = ST_FINISH;
        endcase
      end
      ST_SWEEP: begin
        if (stat.sweep_last) state_next = ST_SRC_A;
      end
      ST_SRC_A:   state_next = ST_SRC_B;
      ST_SRC_B:   state_next = ST_FINISH;
      ST_POKE_RD: state_next = ST_POKE_WR;
      ST_POKE_WR: state_next = ST_FINISH;
      ST_READ_RD: state_next = ST_FINISH;
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SWEEP:   cmd.sweep_step = 1'b1;
      ST_SRC_A:   cmd.src_a_wr = 1'b1;
      ST_SRC_B: begin
        cmd.src_b_wr = 1'b1;
        cmd.rotate   = 1'b1;
      end
      ST_POKE_RD: cmd.poke_rd = 1'b1;
      ST_POKE_WR: cmd.poke_wr = 1'b1;
      ST_READ_RD: cmd.read_rd = 1'b1;
      ST_FINISH:  cmd.load_out = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/wfs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_datapath - grid memories, stencil pipeline, source generator
// Three grid RAMs rotate through current / previous / next roles. The sweep
// streams the current grid through a two-column line buffer into a five
// stage multiply pipeline; an iterative CORDIC makes the source sine.
// ----------------------------------------------------------------------------
module wfs_datapath import wfs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_stat_t                  stat,
  // request fields
  input  logic [KIND_W-1:0]         kind,
  input  logic [COL_W-1:0]          cell_col,
  input  logic [ROW_W-1:0]          cell_row,
  input  logic                      spin_up,
  // configuration
  input  logic [CFG_W-1:0]          wave_gain,
  input  logic [CFG_W-1:0]          damping,
  // result register
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [VALUE_W-1:0] res_cell_value,
  output logic                      res_is_measured,
  output logic                      res_spin_positive,
  output logic [COL_W-1:0]          res_col_a,
  output logic [COL_W-1:0]          res_col_b
);

  // --------------------------------------------------------------------------
  // Latched request
  kind_t             item_kind;
  logic [COL_W-1:0]  item_col;
  logic [ROW_W-1:0]  item_row;
  logic [ADDR_W-1:0] item_addr;
  logic              poke_ok;
  logic              read_ok;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= kind_t'(kind);
      item_col  <= cell_col;
      item_row  <= cell_row;
    end
  end

  assign item_addr = ADDR_W'(ADDR_W'(item_col) * ADDR_W'(GRID_ROWS)) + ADDR_W'(item_row);
  assign poke_ok = (int'(item_col) >= 1) && (int'(item_col) < GRID_COLS - 1) &&
                   (int'(item_row) >= 1) && (int'(item_row) < GRID_ROWS - 1);
  assign read_ok = (int'(item_col) < GRID_COLS) && (int'(item_row) < GRID_ROWS);

  // --------------------------------------------------------------------------
  // Spin, phase and source positions
  logic                measured;
  logic                spin;
  logic [31:0]         phase;
  logic [31:0]         phase_next;
  logic [TENTHS_W-1:0] a_pos;
  logic [TENTHS_W-1:0] b_pos;

  assign phase_next = phase + PHASE_STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      measured <= 1'b0;
      spin     <= 1'b0;
      phase    <= '0;
      a_pos    <= TENTHS_W'(POS_RESET);
      b_pos    <= TENTHS_W'(POS_RESET);
    end else if (cmd.accept) begin
      if (kind_t'(kind) == KIND_TICK) begin
        phase <= phase_next;
        if (int'(a_pos) < A_LIMIT) a_pos <= a_pos + TENTHS_W'(POS_STEP);
        if (int'(b_pos) > B_LIMIT) b_pos <= b_pos - TENTHS_W'(POS_STEP);
      end
      if (kind_t'(kind) == KIND_MEASURE && !measured) begin
        measured <= 1'b1;
        spin     <= spin_up;
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC sine, one rotation per cycle, started by a tick request
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [31:0]         cz;
  logic [CSTEP_W-1:0]         c_step;
  logic                       c_run;
  logic signed [33:0]         ph_s;
  logic signed [33:0]         ph_f;
  logic signed [CORDIC_W-1:0] c_dx;
  logic signed [CORDIC_W-1:0] c_dy;

  // fold the angle into [-pi/2, pi/2]
  always_comb begin
    ph_s = 34'(signed'(phase_next));
    if (ph_s > 34'sd1073741824) begin
      ph_f = 34'sd2147483648 - ph_s;
    end else if (ph_s < -34'sd1073741824) begin
      ph_f = -34'sd2147483648 - ph_s;
    end else begin
      ph_f = ph_s;
    end
  end

  assign c_dx = cy >>> c_step;
  assign c_dy = cx >>> c_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_run  <= 1'b0;
      c_step <= '0;
    end else if (cmd.accept && kind_t'(kind) == KIND_TICK) begin
      c_run  <= 1'b1;
      c_step <= '0;
    end else if (c_run) begin
      c_step <= c_step + CSTEP_W'(1);
      if (c_step == CSTEP_W'(CORDIC_N - 1)) c_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && kind_t'(kind) == KIND_TICK) begin
      cx <= CORDIC_W'(CORDIC_X0);
      cy <= '0;
      cz <= ph_f[31:0];
    end else if (c_run) begin
      if (!cz[31]) begin
        cx <= cx - c_dx;
        cy <= cy + c_dy;
        cz <= cz - atan_turn(c_step);
      end else begin
        cx <= cx + c_dx;
        cy <= cy - c_dy;
        cz <= cz + atan_turn(c_step);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source values and addresses
  logic signed [15:0]          sin_q;
  logic signed [21:0]          src_sine;
  logic signed [WIDE_W-1:0]    src_v;
  logic signed [CELL_BITS-1:0] src_pos;
  logic signed [CELL_BITS-1:0] src_neg;
  logic [QUOT_W-1:0]           qa;
  logic [QUOT_W-1:0]           qb;
  logic [CIDX_W-1:0]           sca;
  logic [CIDX_W-1:0]           scb;
  logic [ADDR_W-1:0]           src_a_addr;
  logic [ADDR_W-1:0]           src_b_addr;

  always_comb begin
    if (cy > CORDIC_W'(32767)) sin_q = 16'sd32767;
    else if (cy < -CORDIC_W'(32768)) sin_q = -16'sd32768;
    else sin_q = cy[15:0];
  end

  assign src_sine = 22'(sin_q) * 22'(SRC_AMP_Q);

  always_comb begin
    if (!measured) src_v = WIDE_W'(src_sine);
    else if (spin) src_v = WIDE_W'(SPIN_AMP);
    else src_v = -WIDE_W'(SPIN_AMP);
  end

  assign src_pos = sat_cell(src_v);
  assign src_neg = sat_cell(-src_v);

  assign qa  = div10(a_pos);
  assign qb  = div10(b_pos);
  assign sca = (int'(qa) > GRID_COLS - 1) ? CIDX_W'(GRID_COLS - 1) : CIDX_W'(qa);
  assign scb = (int'(qb) > GRID_COLS - 1) ? CIDX_W'(GRID_COLS - 1) : CIDX_W'(qb);
  assign src_a_addr = ADDR_W'(ADDR_W'(sca) * ADDR_W'(GRID_ROWS)) + ADDR_W'(GRID_ROWS / 2);
  assign src_b_addr = ADDR_W'(ADDR_W'(scb) * ADDR_W'(GRID_ROWS)) + ADDR_W'(GRID_ROWS / 2);

  // --------------------------------------------------------------------------
  // Clear counter and grid roles
  logic [ADDR_W-1:0] clr_cnt;
  logic [SEL_W-1:0]  cur_sel;
  logic [SEL_W-1:0]  prv_sel;
  logic [SEL_W-1:0]  wrk_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      cur_sel <= SEL_CUR0;
      prv_sel <= SEL_PRV0;
      wrk_sel <= SEL_WRK0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
      if (cmd.rotate) begin
        prv_sel <= cur_sel;
        cur_sel <= wrk_sel;
        wrk_sel <= prv_sel;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sweep counters: read index and stencil center
  logic [SWEEP_W-1:0] sw_cnt;
  logic               sweep_last;
  logic               center_ok;
  logic [ADDR_W-1:0]  sw_cur_addr;
  logic [ADDR_W-1:0]  sw_prv_addr;
  logic [CIDX_W-1:0]  ccol;
  logic [RIDX_W-1:0]  crow;
  logic [ADDR_W-1:0]  clin;
  logic               c_interior;

  assign sweep_last  = sw_cnt == SWEEP_W'(SWEEP_LEN - 1);
  assign center_ok   = cmd.sweep_step && (int'(sw_cnt) >= GRID_ROWS) &&
                       (int'(sw_cnt) < NCELLS + GRID_ROWS);
  assign sw_cur_addr = (int'(sw_cnt) < NCELLS) ? sw_cnt[ADDR_W-1:0] : '0;
  assign sw_prv_addr = clin;
  assign c_interior  = (int'(ccol) >= 1) && (int'(ccol) < GRID_COLS - 1) &&
                       (int'(crow) >= 1) && (int'(crow) < GRID_ROWS - 1);

  always_ff @(posedge clk) begin
    if (rst || !cmd.sweep_step) begin
      sw_cnt <= '0;
      ccol   <= '0;
      crow   <= '0;
      clin   <= '0;
    end else begin
      sw_cnt <= sw_cnt + SWEEP_W'(1);
      if (center_ok) begin
        clin <= clin + ADDR_W'(1);
        if (crow == RIDX_W'(GRID_ROWS - 1)) begin
          crow <= '0;
          ccol <= ccol + CIDX_W'(1);
        end else begin
          crow <= crow + RIDX_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Grid memories
  logic                         m_we    [NUM_RAMS];
  logic [ADDR_W-1:0]            m_waddr [NUM_RAMS];
  logic [CELL_BITS-1:0]         m_wdata [NUM_RAMS];
  logic                         m_re    [NUM_RAMS];
  logic [ADDR_W-1:0]            m_raddr [NUM_RAMS];
  logic [CELL_BITS-1:0]         m_rdata [NUM_RAMS];
  logic signed [CELL_BITS-1:0]  cur_q;
  logic signed [CELL_BITS-1:0]  prv_q;
  logic signed [CELL_BITS-1:0]  cur_poke;
  logic signed [CELL_BITS-1:0]  prv_poke;
  logic                         wk_we;
  logic [ADDR_W-1:0]            wk_addr;
  logic signed [CELL_BITS-1:0]  wk_data;

  assign cur_q    = signed'(m_rdata[cur_sel]);
  assign prv_q    = signed'(m_rdata[prv_sel]);
  assign cur_poke = sat_cell(WIDE_W'(cur_q) + WIDE_W'(POKE_AMP));
  assign prv_poke = sat_cell(WIDE_W'(prv_q) + WIDE_W'(POKE_AMP));

  for (genvar m = 0; m < NUM_RAMS; m++) begin : g_ram
    // port steering by role
    always_comb begin
      m_we[m]    = 1'b0;
      m_waddr[m] = '0;
      m_wdata[m] = '0;
      m_re[m]    = 1'b0;
      m_raddr[m] = '0;
      if (cmd.clr_step) begin
        m_we[m]    = 1'b1;
        m_waddr[m] = clr_cnt;
      end else if (cur_sel == SEL_W'(m)) begin
        if (cmd.sweep_step) begin
          m_re[m]    = 1'b1;
          m_raddr[m] = sw_cur_addr;
        end
        if (cmd.poke_rd || cmd.read_rd) begin
          m_re[m]    = 1'b1;
          m_raddr[m] = item_addr;
        end
        if (cmd.src_a_wr) begin
          m_we[m]    = 1'b1;
          m_waddr[m] = src_a_addr;
          m_wdata[m] = src_pos;
        end
        if (cmd.src_b_wr) begin
          m_we[m]    = 1'b1;
          m_waddr[m] = src_b_addr;
          m_wdata[m] = src_neg;
        end
        if (cmd.poke_wr) begin
          m_we[m]    = 1'b1;
          m_waddr[m] = item_addr;
          m_wdata[m] = cur_poke;
        end
      end else if (prv_sel == SEL_W'(m)) begin
        if (cmd.sweep_step) begin
          m_re[m]    = 1'b1;
          m_raddr[m] = sw_prv_addr;
        end
        if (cmd.poke_rd) begin
          m_re[m]    = 1'b1;
          m_raddr[m] = item_addr;
        end
        if (cmd.poke_wr) begin
          m_we[m]    = 1'b1;
          m_waddr[m] = item_addr;
          m_wdata[m] = prv_poke;
        end
      end else begin
        m_we[m]    = wk_we;
        m_waddr[m] = wk_addr;
        m_wdata[m] = wk_data;
      end
    end

    wfs_ram #(
      .DEPTH (NCELLS),
      .WIDTH (CELL_BITS)
    ) u_ram (
      .clk   (clk),
      .we    (m_we[m]),
      .waddr (m_waddr[m]),
      .wdata (m_wdata[m]),
      .re    (m_re[m]),
      .raddr (m_raddr[m]),
      .rdata (m_rdata[m])
    );
  end

  // --------------------------------------------------------------------------
  // Line buffer: two columns of the current grid behind the newest read
  logic                        rd_d;
  logic signed [CELL_BITS-1:0] line [2*GRID_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_d <= 1'b0;
    end else begin
      rd_d <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_d) begin
      line[0] <= cur_q;
      for (int i = 1; i < 2 * GRID_ROWS; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stencil pipeline
  logic                     s0_v, a_v, b_v, c_v, d_v;
  logic                     s0_int, a_int, b_int, c_int, d_int;
  logic [ADDR_W-1:0]        s0_j, a_j, b_j, c_j, d_j;
  logic signed [LAP_W-1:0]  lap;
  logic signed [LAP_W-1:0]  base;
  logic signed [LAP_W-1:0]  a_lap, a_base, b_base;
  logic signed [PG_W-1:0]   b_prod;
  logic signed [NV_W-1:0]   c_nv;
  logic signed [PD_W-1:0]   d_prod;
  logic signed [16:0]       gain_s;
  logic signed [16:0]       damp_s;

  assign gain_s = signed'({1'b0, wave_gain});
  assign damp_s = signed'({1'b0, damping});

  // laplacian and 2c - p; east is the RAM output, others are line taps
  assign lap = LAP_W'(cur_q) + LAP_W'(line[2*GRID_ROWS-1]) + LAP_W'(line[GRID_ROWS])
             + LAP_W'(line[GRID_ROWS-2]) - (LAP_W'(line[GRID_ROWS-1]) <<< 2);
  assign base = (LAP_W'(line[GRID_ROWS-1]) <<< 1) - LAP_W'(prv_q);

  // valid tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      c_v  <= 1'b0;
      d_v  <= 1'b0;
    end else begin
      s0_v <= center_ok;
      a_v  <= s0_v;
      b_v  <= a_v;
      c_v  <= b_v;
      d_v  <= c_v;
    end
  end

  // arithmetic stages; the gain multiply is in stage b, the damping multiply in d
  always_ff @(posedge clk) begin
    s0_j   <= clin;
    s0_int <= c_interior;
    a_j    <= s0_j;
    a_int  <= s0_int;
    a_lap  <= lap;
    a_base <= base;
    b_j    <= a_j;
    b_int  <= a_int;
    b_base <= a_base;
    b_prod <= PG_W'(a_lap) * PG_W'(gain_s) + PG_W'(Q16_ROUND);
    c_j    <= b_j;
    c_int  <= b_int;
    c_nv   <= NV_W'(b_base) + NV_W'(b_prod >>> 16);
    d_j    <= c_j;
    d_int  <= c_int;
    d_prod <= PD_W'(c_nv) * PD_W'(damp_s) + PD_W'(Q16_ROUND);
  end

  assign wk_we   = d_v;
  assign wk_addr = d_j;
  assign wk_data = d_int ? sat_cell(WIDE_W'(d_prod >>> 16)) : '0;

  // --------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_cell_value    <= (item_kind == KIND_READ && read_ok) ?
                           sat_value(WIDE_W'(cur_q)) : '0;
      res_is_measured   <= measured;
      res_spin_positive <= measured & spin;
      res_col_a         <= qa[COL_W-1:0];
      res_col_b         <= qb[COL_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Status to controller
  assign stat.clr_last   = clr_cnt == ADDR_W'(NCELLS - 1);
  assign stat.sweep_last = sweep_last;
  assign stat.kind       = item_kind;
  assign stat.poke_ok    = poke_ok;
  assign stat.read_ok    = read_ok;
  assign stat.out_free   = !res_valid || res_ready;

endmodule
`default_nettype wire

@@ rtl/core/wave_grid_fdtd_step_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wave_grid_fdtd_step_unit - damped 2D wave stencil with two moving sources
// Top level: configuration registers, controller, datapath.
//
//   channel  | dir | handshake           | content
//   ---------+-----+---------------------+--------------------------------------
//   item     | in  | valid / ready       | kind, cell_col, cell_row, spin_up
//   result   | out | valid / ready       | cell_value, is_measured, spin_positive,
//            |     |                     | col_a, col_b
//   apb      | in  | psel/penable/pready | wave_gain (0x0), damping (0x4)
//
// One request at a time. A tick streams one grid cell per cycle through the
// stencil pipeline (all cells, one more column, drain). Poke steps decode,
// read, write, finish; read steps decode, read, finish; measure decode,
// finish; each may wait on result.ready. A post-reset pass zeroes the grids;
// item.ready stays low in it. A finished result waits in the output register.
// ----------------------------------------------------------------------------
module wave_grid_fdtd_step_unit import wfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  wfs_item_if.sink           item,
  wfs_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [CFG_W-1:0] wave_gain;
  logic [CFG_W-1:0] damping;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_gain <= GAIN_RESET;
      damping   <= DAMP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WAVE_GAIN) wave_gain <= pwdata[CFG_W-1:0];
      else damping <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DAMPING) ? APB_DW'(damping) : APB_DW'(wave_gain);

  // controller
  wfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  wfs_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .kind              (item.kind),
    .cell_col          (item.cell_col),
    .cell_row          (item.cell_row),
    .spin_up           (item.spin_up),
    .wave_gain         (wave_gain),
    .damping           (damping),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_cell_value    (result.cell_value),
    .res_is_measured   (result.is_measured),
    .res_spin_positive (result.spin_positive),
    .res_col_a         (result.col_a),
    .res_col_b         (result.col_b)
  );

`ifndef SYNTHESIS
  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("request accepted while another was in flight");

  // a positive spin is only reported after a measurement
  a_spin_needs_measure: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.spin_positive |-> result.is_measured)
    else $error("spin reported before measurement");

  // a new result is only loaded after a request was taken
  a_result_after_request: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !item.ready)
    else $error("result loaded while idle");
`endif

endmodule
`default_nettype wire
